// File: rtl/marup_pkg.sv
// marup_pkg: shared types and constants of the modulo address register update core
// used by the channel interfaces and the top level; no dependencies
package marup_pkg;

   localparam int NUM_ADDR_REGS_DEF = 4;
   localparam int ADDR_WIDTH_DEF    = 16;

   // fixed widths of the channel fields
   localparam int CMD_W   = 3;
   localparam int SEL_W   = 2;
   localparam int FIELD_W = 16;
   // step count holds |index| up to 2^(FIELD_W-1)
   localparam int COUNT_W = FIELD_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 3'd0,
      CMD_FWD  = 3'd1,
      CMD_BACK = 3'd2,
      CMD_ADD  = 3'd3,
      CMD_SUB  = 3'd4
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

endpackage

// File: rtl/marup_if.sv
// marup_if: request and response channel interfaces (valid/ready handshake)
// depends on marup_pkg for the field widths
interface marup_req_if import marup_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [SEL_W-1:0]          register_select;
   logic [FIELD_W-1:0]        wrap_length;
   logic signed [FIELD_W-1:0] step_index;
   logic [FIELD_W-1:0]        load_value;

   modport source (output valid, command, register_select, wrap_length, step_index,
                   load_value, input ready);
   modport sink (input valid, command, register_select, wrap_length, step_index,
                 load_value, output ready);
endinterface

interface marup_rsp_if import marup_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SEL_W-1:0]   register_echo;
   logic [FIELD_W-1:0] new_address;

   modport source (output valid, register_echo, new_address, input ready);
   modport sink (input valid, register_echo, new_address, output ready);
endinterface

// File: rtl/modulo_address_register_update_core.sv
// modulo_address_register_update_core: circular-buffer address unit with modulo registers
// depends on marup_pkg and the channel interfaces in marup_if.sv
//
// Usage:
//   req_chan carries one command per transfer: load, step forward, step back, or
//   add/subtract a signed index against one address register with its wrap length.
//   rsp_chan returns one transfer per command: the register number and its new value;
//   a register number of NUM_ADDR_REGS or more changes nothing and returns address zero.
// Timing:
//   req_chan.ready is high only while the core is idle. After a transfer the core
//   applies the wrap steps one at a time in a single shared step unit (load: none, step
//   commands: one, add/subtract: |index|, up to 32768), then writes the register and
//   posts the response once the response slot is free; only then does it return to
//   idle and take the next request.
// Stall:
//   the response sits in an output register, so the next request is taken while it
//   waits; that next command holds its result until the response slot is free.
// Reset:
//   synchronous, active high; all address registers clear to zero, no response pending.
module modulo_address_register_update_core
   import marup_pkg::*;
#(
   parameter int NUM_ADDR_REGS = NUM_ADDR_REGS_DEF,
   parameter int ADDR_WIDTH    = ADDR_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   marup_req_if.sink   req_chan,
   marup_rsp_if.source rsp_chan
);

   localparam int IdxW = (NUM_ADDR_REGS > 1) ? $clog2(NUM_ADDR_REGS) : 1;

   state_type              state_ff, state_in;
   logic [ADDR_WIDTH-1:0]  regs_ff [NUM_ADDR_REGS];
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [ADDR_WIDTH-1:0]  addr_ff, addr_in;
   logic [ADDR_WIDTH-1:0]  wrap_ff, wrap_in;
   logic [ADDR_WIDTH-1:0]  mask_ff, mask_in;
   logic                   fwd_ff, fwd_in;
   logic                   sel_ok_ff, sel_ok_in;
   logic [IdxW-1:0]        idx_ff, idx_in;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic [SEL_W-1:0]       rsp_echo_ff, rsp_echo_in;
   logic [FIELD_W-1:0]     rsp_addr_ff, rsp_addr_in;

   logic                   req_xfer, rsp_xfer, finish;
   logic                   neg;
   logic [COUNT_W-1:0]     mag;
   logic [ADDR_WIDTH-1:0]  fill;
   logic [ADDR_WIDTH-1:0]  back_m, step_res;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_chan.ready;
   // result leaves the sequencer only when the response slot is free
   assign finish   = (state_ff == ST_RUN) && (count_ff == '0) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.register_echo = rsp_echo_ff;
   assign rsp_chan.new_address   = rsp_addr_ff;

   // wrap mask: wrap length with all bits below its top set bit filled in
   always_comb begin
      fill = ADDR_WIDTH'(req_chan.wrap_length);
      for (int k = 0; k < 5; k++) begin
         if ((1 << k) < ADDR_WIDTH) begin
            fill = fill | (fill >> (1 << k));
         end
      end
   end

   // shared single wrap step unit
   always_comb begin
      back_m = (mask_ff + ADDR_WIDTH'(1) - addr_ff) & mask_ff;
      if (fwd_ff) begin
         if ((addr_ff & mask_ff) == mask_ff) begin
            step_res = addr_ff - wrap_ff;
         end else begin
            step_res = addr_ff + ADDR_WIDTH'(1);
         end
      end else begin
         if ((wrap_ff < back_m) || (back_m == '0)) begin
            step_res = addr_ff + wrap_ff;
         end else begin
            step_res = addr_ff - ADDR_WIDTH'(1);
         end
      end
   end

   always_comb begin
      neg = req_chan.step_index[FIELD_W-1];
      mag = neg ? (COUNT_W'(1) << (COUNT_W - 1)) - {1'b0, req_chan.step_index}
                : {1'b0, req_chan.step_index};
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      addr_in      = addr_ff;
      wrap_in      = wrap_ff;
      mask_in      = mask_ff;
      fwd_in       = fwd_ff;
      sel_ok_in    = sel_ok_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_addr_in  = rsp_addr_ff;

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in  = ST_RUN;
               sel_in    = req_chan.register_select;
               sel_ok_in = 32'(req_chan.register_select) < NUM_ADDR_REGS;
               idx_in    = IdxW'(req_chan.register_select);
               wrap_in   = ADDR_WIDTH'(req_chan.wrap_length);
               mask_in   = fill;
               addr_in   = sel_ok_in ? regs_ff[idx_in] : '0;
               fwd_in    = 1'b1;
               count_in  = '0;
               case (cmd_type'(req_chan.command))
                  CMD_LOAD: addr_in = ADDR_WIDTH'(req_chan.load_value);
                  CMD_FWD: begin
                     fwd_in   = 1'b1;
                     count_in = COUNT_W'(1);
                  end
                  CMD_BACK: begin
                     fwd_in   = 1'b0;
                     count_in = COUNT_W'(1);
                  end
                  CMD_ADD: begin
                     fwd_in   = !neg;
                     count_in = mag;
                  end
                  CMD_SUB: begin
                     fwd_in   = neg;
                     count_in = mag;
                  end
                  default: count_in = '0;
               endcase
            end
         end
         ST_RUN: begin
            if (count_ff != '0) begin
               addr_in  = step_res;
               count_in = count_ff - COUNT_W'(1);
            end else if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_echo_in  = sel_ff;
               rsp_addr_in  = sel_ok_ff ? FIELD_W'(addr_ff) : '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ADDR_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish && sel_ok_ff) begin
            regs_ff[idx_ff] <= addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      wrap_ff     <= wrap_in;
      mask_ff     <= mask_in;
      fwd_ff      <= fwd_in;
      sel_ok_ff   <= sel_ok_in;
      idx_ff      <= idx_in;
      sel_ff      <= sel_in;
      rsp_echo_ff <= rsp_echo_in;
      rsp_addr_ff <= rsp_addr_in;
   end

`ifndef SYNTHESIS
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && count_ff != '0) |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("step count did not decrement by one");

   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RUN)
      else $error("response posted without a finished command");

   a_req_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_RUN)
      else $error("request transfer did not start the sequencer");

   a_bad_sel_zero: assert property (@(posedge clock) disable iff (reset)
      (finish && !sel_ok_ff) |=> rsp_addr_ff == '0)
      else $error("out-of-range register returned a nonzero address");
`endif

endmodule

// File: tb/modulo_address_register_update_core_tb.sv
// modulo_address_register_update_core_tb: self-checking bench for the modulo address core
// drives commands, predicts each new register value and compares every response transfer
// depends on marup_pkg, marup_if.sv and modulo_address_register_update_core
`timescale 1ns / 100ps

module modulo_address_register_update_core_tb;
   import marup_pkg::*;

   localparam int                 NUM_REGS        = NUM_ADDR_REGS_DEF;
   localparam int                 RANDOM_CMDS     = 80;
   localparam int                 LONG_RUN_BUDGET = 3;
   localparam logic [CMD_W-1:0]   CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]   CMD_SPARE_LAST  = 3'd7;
   localparam logic [FIELD_W-1:0] ADDR_ONES       = '1;

   typedef struct {
      logic [CMD_W-1:0]          command;
      logic [SEL_W-1:0]          sel;
      logic [FIELD_W-1:0]        wrap;
      logic signed [FIELD_W-1:0] index;
      logic [FIELD_W-1:0]        load;
   } addr_cmd_type;

   typedef struct {
      logic [SEL_W-1:0]   reg_num;
      logic [FIELD_W-1:0] addr;
   } addr_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   marup_req_if req_chan ();
   marup_rsp_if rsp_chan ();

   modulo_address_register_update_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   addr_cmd_type       pending_cmds[$];
   addr_result_type    expected_addrs[$];
   logic [FIELD_W-1:0] addr_regs[NUM_REGS];
   int                 total_cmds     = 0;
   int                 accepted_count = 0;
   int                 error_count    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [FIELD_W-1:0] fill_below_top(input logic [FIELD_W-1:0] w);
      logic [FIELD_W-1:0] m;
      m = w;
      for (int s = 1; s < FIELD_W; s = s << 1)
         m = m | (m >> s);
      return m;
   endfunction

   function automatic logic [FIELD_W-1:0] wrap_forward(input logic [FIELD_W-1:0] a,
                                                       input logic [FIELD_W-1:0] wrap,
                                                       input logic [FIELD_W-1:0] mask);
      if ((a & mask) == mask)
         return a - wrap;
      return a + 1'b1;
   endfunction

   function automatic logic [FIELD_W-1:0] wrap_backward(input logic [FIELD_W-1:0] a,
                                                        input logic [FIELD_W-1:0] wrap,
                                                        input logic [FIELD_W-1:0] mask);
      logic [FIELD_W-1:0] gap;
      gap = (mask + 1'b1 - a) & mask;
      if (wrap < gap || gap == '0)
         return a + wrap;
      return a - 1'b1;
   endfunction

   function automatic addr_result_type update_address(input addr_cmd_type c);
      addr_result_type    r;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] mask;
      logic [COUNT_W-1:0] steps;
      logic               neg;
      logic               forward;
      a     = addr_regs[c.sel];
      mask  = fill_below_top(c.wrap);
      neg   = c.index[FIELD_W-1];
      steps = neg ? ((COUNT_W'(1) << (FIELD_W)) - {1'b0, c.index}) : {1'b0, c.index};
      case (c.command)
         CMD_LOAD: a = c.load;
         CMD_FWD:  a = wrap_forward(a, c.wrap, mask);
         CMD_BACK: a = wrap_backward(a, c.wrap, mask);
         CMD_ADD, CMD_SUB: begin
            // a negative index reverses the direction of the command
            forward = (c.command == CMD_ADD) ? !neg : neg;
            for (int k = 0; k < steps; k++)
               a = forward ? wrap_forward(a, c.wrap, mask) : wrap_backward(a, c.wrap, mask);
         end
         default: ;
      endcase
      addr_regs[c.sel] = a;
      r.reg_num = c.sel;
      r.addr    = a;
      return r;
   endfunction

   // ---------------------------------------------------------------- traffic shaping

   function automatic int traffic_phase();
      if (total_cmds == 0)
         return 0;
      return (accepted_count * 3) / total_cmds;
   endfunction

   function automatic int sender_idle_pct();
      case (traffic_phase())
         0:       return 10;
         1:       return 81;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (traffic_phase())
         0:       return 81;
         1:       return 10;
         default: return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
            req_chan.command         <= pending_cmds[0].command;
            req_chan.register_select <= pending_cmds[0].sel;
            req_chan.wrap_length     <= pending_cmds[0].wrap;
            req_chan.step_index      <= pending_cmds[0].index;
            req_chan.load_value      <= pending_cmds[0].load;
            req_chan.valid           <= 1'b1;
            void'(pending_cmds.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      addr_cmd_type    c;
      addr_result_type e;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            c.command = req_chan.command;
            c.sel     = req_chan.register_select;
            c.wrap    = req_chan.wrap_length;
            c.index   = req_chan.step_index;
            c.load    = req_chan.load_value;
            expected_addrs.push_back(update_address(c));
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_addrs.size() == 0) begin
               $display("%0t: unexpected transfer: register %0d address %h", $time,
                        rsp_chan.register_echo, rsp_chan.new_address);
               error_count++;
            end else begin
               e = expected_addrs.pop_front();
               if (rsp_chan.register_echo !== e.reg_num) begin
                  $display("%0t: register_echo expected %0d actual %0d", $time,
                           e.reg_num, rsp_chan.register_echo);
                  error_count++;
               end
               if (rsp_chan.new_address !== e.addr) begin
                  $display("%0t: new_address expected %h actual %h", $time,
                           e.addr, rsp_chan.new_address);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic addr_cmd_type make_cmd(input logic [CMD_W-1:0] command,
                                             input logic [SEL_W-1:0] sel,
                                             input logic [FIELD_W-1:0] wrap,
                                             input logic signed [FIELD_W-1:0] index,
                                             input logic [FIELD_W-1:0] load);
      addr_cmd_type c;
      c.command = command;
      c.sel     = sel;
      c.wrap    = wrap;
      c.index   = index;
      c.load    = load;
      return c;
   endfunction

   function automatic logic [FIELD_W-1:0] pick_wrap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return FIELD_W'($urandom_range(1, 63));
      if (r < 70)
         return FIELD_W'($urandom_range(64, 4095));
      if (r < 85)
         return FIELD_W'($urandom);
      if (r < 95)
         return '0;
      return ADDR_ONES;
   endfunction

   initial begin : stimulus
      logic [FIELD_W-1:0] buffer_wrap[NUM_REGS];
      logic [FIELD_W-1:0] mask;
      addr_cmd_type       c;
      int                 long_runs_left;
      int                 r;
      int                 sel;

      req_chan.valid           = 1'b0;
      req_chan.command         = CMD_LOAD;
      req_chan.register_select = '0;
      req_chan.wrap_length     = '0;
      req_chan.step_index      = '0;
      req_chan.load_value      = '0;
      rsp_chan.ready           = 1'b0;
      for (int i = 0; i < NUM_REGS; i++)
         addr_regs[i] = '0;

      // directed: field extremes, wrap edges, zero and negative index, long runs
      pending_cmds.push_back(make_cmd(CMD_FWD,  0, 16'h0000, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_BACK, 0, 16'h0000, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 1, 16'hFFFF, 16'sh7FFF, 16'hFFFF));
      pending_cmds.push_back(make_cmd(CMD_FWD,  1, 16'hFFFF, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_BACK, 1, 16'hFFFF, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 3, 16'h000F, 16'sh0000, 16'h00F0));
      pending_cmds.push_back(make_cmd(CMD_FWD,  3, 16'h000F, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 3, 16'h000F, 16'sh0000, 16'h00FF));
      pending_cmds.push_back(make_cmd(CMD_FWD,  3, 16'h000F, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_BACK, 3, 16'h000F, 16'sh0000, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_ADD,  3, 16'h000F, 16'sh0005, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_ADD,  3, 16'h000F, -16'sd7,   16'h0000));
      pending_cmds.push_back(make_cmd(CMD_SUB,  3, 16'h000F, 16'sh0003, 16'h0000));
      pending_cmds.push_back(make_cmd(CMD_SUB,  3, 16'h000F, -16'sd20,  16'h0000));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 2, 16'h0005, 16'sh0000, 16'h1234));
      pending_cmds.push_back(make_cmd(CMD_ADD,  2, 16'h0005, 16'sh0000, 16'hFFFF));
      pending_cmds.push_back(make_cmd(CMD_SUB,  2, 16'h0005, 16'sh0000, 16'hFFFF));
      pending_cmds.push_back(make_cmd(CMD_ADD,  0, 16'h00FF, 16'sh7FFF, 16'hA5A5));
      pending_cmds.push_back(make_cmd(CMD_SUB,  1, 16'h0100, 16'sh8000, 16'h5A5A));
      pending_cmds.push_back(make_cmd(CMD_ADD,  2, 16'h7FFF, 16'sh8000, 16'h0000));
      for (logic [CMD_W:0] k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
         pending_cmds.push_back(make_cmd(k[CMD_W-1:0], SEL_W'(k), 16'hFFFF, 16'sh7FFF,
                                         16'hFFFF));

      // random: per-register circular buffers, mostly consistent wrap, some noise
      long_runs_left = LONG_RUN_BUDGET;
      for (int i = 0; i < NUM_REGS; i++)
         buffer_wrap[i] = pick_wrap();
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         sel = $urandom_range(0, NUM_REGS - 1);
         if ($urandom_range(0, 7) == 0)
            buffer_wrap[sel] = pick_wrap();
         c.sel  = SEL_W'(sel);
         c.wrap = ($urandom_range(0, 19) == 0) ? FIELD_W'($urandom) : buffer_wrap[sel];
         mask   = fill_below_top(c.wrap);
         r      = $urandom_range(0, 99);
         if (r < 15)
            c.command = CMD_LOAD;
         else if (r < 40)
            c.command = CMD_FWD;
         else if (r < 65)
            c.command = CMD_BACK;
         else if (r < 80)
            c.command = CMD_ADD;
         else if (r < 95)
            c.command = CMD_SUB;
         else
            c.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
         // loads mostly land inside an aligned buffer of wrap+1 entries
         if ($urandom_range(0, 4) == 0)
            c.load = FIELD_W'($urandom);
         else
            c.load = (FIELD_W'($urandom) & ~mask) | (FIELD_W'($urandom_range(0, c.wrap)) & mask);
         // full-range index is rare and capped, it costs up to 32768 wrap steps
         r = $urandom_range(0, 99);
         if (r < 2 && long_runs_left > 0) begin
            long_runs_left--;
            c.index = FIELD_W'($urandom);
         end else if (r < 20) begin
            c.index = FIELD_W'($urandom_range(0, 1200) - 600);
         end else begin
            c.index = FIELD_W'($urandom_range(0, 80) - 40);
         end
         pending_cmds.push_back(c);
      end
      total_cmds = pending_cmds.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_cmds)
         @(negedge clock);
      while (expected_addrs.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      if (error_count == 0 && expected_addrs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #15_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
